// ----- design/lrwr_pkg.sv -----
package lrwr_pkg;

  localparam int LETTER_W = 5;
  localparam int LEN_W    = 11;

  typedef struct packed {
    logic [LETTER_W-1:0] letter_code;
    logic                string_start;
    logic                string_end;
  } lrwr_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] best_length;
    logic             final_result;
    logic             too_long;
  } lrwr_out_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_UPDATE,
    PH_RETIRE
  } lrwr_phase_t;

endpackage

// ----- design/lrwr_ram.sv -----
module lrwr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/longest_run_with_replacements_unit.sv -----
// Each accepted item passes through an update phase, where its result is registered,
// and no new item is taken in that phase; the letter-count memory writes the item's
// increment in the update phase and the dropped letter's decrement in the retire phase.
// Reset: window registers, flags and the replacement limit clear at once; the
// letter store is not cleared and needs no clearing pass after reset.
module longest_run_with_replacements_unit #(
  parameter int STORE_DEPTH   = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  lrwr_pkg::lrwr_in_t                item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output lrwr_pkg::lrwr_out_t               result,
  input  logic                              cfg_wr_en,
  input  logic [lrwr_pkg::LEN_W-1:0]        cfg_wr_data
);

  import lrwr_pkg::*;

  localparam int SAW  = $clog2(STORE_DEPTH);
  localparam int CAW  = $clog2(ALPHABET_SIZE);
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;
  localparam logic [8:0]    ALPHA_LIM = 9'(ALPHABET_SIZE);
  localparam logic [CW-1:0] DEPTH_LIM = CW'(STORE_DEPTH);
  localparam logic [SAW-1:0] LAST_POS = SAW'(STORE_DEPTH - 1);

  lrwr_phase_t state, state_next;

  logic                 accept;
  logic [LEN_W-1:0]     k;
  logic [SAW-1:0]       window_start;
  logic [CW-1:0]        window_size;
  logic [CW-1:0]        top_count;
  logic [CW-1:0]        letters_seen;
  logic                 overflow_flag;
  logic [ALPHABET_SIZE-1:0] cnt_valid;

  // item held for the update cycle
  logic [LETTER_W-1:0]  code_r;
  logic                 start_r;
  logic                 last_r;
  logic                 valid_r;
  logic                 fwd_hit;
  logic [CW-1:0]        fwd_data;
  // pending decrement of the dropped letter
  logic                 dec_pend;
  logic [CAW-1:0]       dec_idx;
  logic                 old_valid_r;

  // memory ports
  logic                 cnt_we;
  logic [CAW-1:0]       cnt_waddr;
  logic [CW-1:0]        cnt_wdata;
  logic                 cnt_re;
  logic [CAW-1:0]       cnt_raddr;
  logic [CW-1:0]        cnt_rdata;
  logic                 st_we;
  logic [LETTER_W-1:0]  st_rdata;

  // update cycle datapath
  logic [CAW-1:0]       in_idx;
  logic [CAW-1:0]       code_idx;
  logic [CAW-1:0]       old_idx;
  logic [CW-1:0]        b_size;
  logic [CW-1:0]        b_top;
  logic [CW-1:0]        b_seen;
  logic [SAW-1:0]       b_ws;
  logic                 b_ov;
  logic                 in_range;
  logic                 take;
  logic                 ov_new;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        cnt_inc;
  logic [CW-1:0]        top_n;
  logic [CW-1:0]        size_inc;
  logic                 drop;
  logic                 old_same;
  logic [CW-1:0]        size_n;
  logic [SAW-1:0]       ws_n;
  logic [CW-1:0]        cnt_old;
  logic                 dec_we;

  assign accept   = item_valid && item_ready;
  assign in_idx   = CAW'(item.letter_code);
  assign code_idx = CAW'(code_r);
  assign old_idx  = CAW'(st_rdata);

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    unique case (state)
      PH_IDLE:   if (accept) state_next = PH_UPDATE;
      PH_UPDATE: state_next = PH_RETIRE;
      PH_RETIRE: state_next = accept ? PH_UPDATE : PH_IDLE;
      default:   state_next = PH_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state != PH_UPDATE) && (!result_valid || result_ready);
    cnt_re     = 1'b0;
    cnt_raddr  = in_idx;
    cnt_we     = 1'b0;
    cnt_waddr  = dec_idx;
    cnt_wdata  = cnt_old - CW'(1);
    st_we      = 1'b0;
    unique case (state)
      PH_IDLE: begin
        cnt_re = accept;
      end
      PH_UPDATE: begin
        // fetch the dropped letter's count while writing this letter's count
        cnt_re    = 1'b1;
        cnt_raddr = old_idx;
        cnt_we    = take;
        cnt_waddr = code_idx;
        cnt_wdata = cnt_inc - CW'(drop && old_same);
        st_we     = take;
      end
      PH_RETIRE: begin
        cnt_re = accept;
        cnt_we = dec_we;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------- memories
  lrwr_ram #(.WIDTH(CW), .DEPTH(ALPHABET_SIZE)) u_counts (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_en   (cnt_re),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  lrwr_ram #(.WIDTH(LETTER_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (SAW'(b_seen)),
    .wr_data (code_r),
    .rd_en   (accept),
    .rd_addr (window_start),
    .rd_data (st_rdata)
  );

  // ---------------------------------------------------------------- update
  always_comb begin
    b_size   = start_r ? '0 : window_size;
    b_top    = start_r ? '0 : top_count;
    b_seen   = start_r ? '0 : letters_seen;
    b_ws     = start_r ? '0 : window_start;
    b_ov     = start_r ? 1'b0 : overflow_flag;
    in_range = 9'(code_r) < ALPHA_LIM;
    take     = in_range && (b_seen < DEPTH_LIM);
    ov_new   = b_ov || (in_range && !take);
    if (start_r) begin
      cnt = '0;
    end else if (fwd_hit) begin
      cnt = fwd_data;
    end else if (valid_r) begin
      cnt = cnt_rdata;
    end else begin
      cnt = '0;
    end
    cnt_inc  = cnt + CW'(1);
    top_n    = (cnt_inc > b_top) ? cnt_inc : b_top;
    size_inc = b_size + CW'(1);
    drop     = CMPW'(size_inc - top_n) > CMPW'(k);
    old_same = st_rdata == code_r;
    size_n   = drop ? b_size : size_inc;
    ws_n     = (b_ws == LAST_POS) ? '0 : b_ws + SAW'(1);
    cnt_old  = old_valid_r ? cnt_rdata : '0;
    dec_we   = dec_pend && (cnt_old != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k             <= '0;
      window_start  <= '0;
      window_size   <= '0;
      top_count     <= '0;
      letters_seen  <= '0;
      overflow_flag <= 1'b0;
      cnt_valid     <= '0;
      dec_pend      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        k <= cfg_wr_data;
      end
      // a new string wins over a late decrement from the previous one
      if (accept && item.string_start) begin
        cnt_valid <= '0;
      end else if (cnt_we) begin
        cnt_valid[cnt_waddr] <= 1'b1;
      end
      if (state == PH_UPDATE) begin
        overflow_flag <= ov_new;
        dec_pend      <= take && drop && !old_same;
        if (take) begin
          window_size  <= size_n;
          top_count    <= top_n;
          letters_seen <= b_seen + CW'(1);
          window_start <= drop ? ws_n : b_ws;
        end else begin
          window_size  <= b_size;
          top_count    <= b_top;
          letters_seen <= b_seen;
          window_start <= b_ws;
        end
        result_valid <= 1'b1;
      end else begin
        if (state == PH_RETIRE) begin
          dec_pend <= 1'b0;
        end
        if (result_ready) begin
          result_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_r   <= item.letter_code;
      start_r  <= item.string_start;
      last_r   <= item.string_end;
      valid_r  <= (9'(item.letter_code) < ALPHA_LIM) && cnt_valid[in_idx];
      // the decrement lands in the same edge as this read: take its value
      fwd_hit  <= (state == PH_RETIRE) && dec_we && (dec_idx == in_idx);
      fwd_data <= cnt_old - CW'(1);
    end
    if (state == PH_UPDATE) begin
      dec_idx     <= old_idx;
      old_valid_r <= (9'(st_rdata) < ALPHA_LIM) && cnt_valid[old_idx];
      result.best_length  <= LEN_W'(take ? size_n : b_size);
      result.final_result <= last_r;
      result.too_long     <= ov_new;
    end
  end

endmodule

// ----- tb/sv/longest_run_with_replacements_unit_tb.sv -----
`timescale 1ns / 1ps

module longest_run_with_replacements_unit_tb;
  import lrwr_pkg::*;

  localparam int STORE_DEPTH   = 1024;
  localparam int ALPHABET_SIZE = 26;
  localparam int MAX_K         = 1024;
  localparam int LONG_HOLD     = 300;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PRINT_MAX     = 50;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  lrwr_in_t         item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  lrwr_out_t        result;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  longest_run_with_replacements_unit #(
    .STORE_DEPTH  (STORE_DEPTH),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sliding window mirror
  logic [LETTER_W-1:0] letter_mem [STORE_DEPTH];
  int                  letter_cnt [ALPHABET_SIZE];
  int                  win_start;
  int                  win_size;
  int                  top_cnt;
  int                  seen_cnt;
  bit                  overflow;
  int                  repl_limit;

  lrwr_in_t  pending_letters[$];
  lrwr_out_t expected_answers[$];

  int  mismatches;
  int  letters_sent;
  int  answers_checked;
  int  strings_closed;
  int  overflow_answers;
  int  settings_used;
  int  idle_cycles;
  int  send_gap;
  int  hold_left;
  int  holds_wanted;
  int  holds_done;
  bit  burst;
  logic drv_next_valid;
  logic mon_next_ready;

  initial begin
    foreach (letter_cnt[i]) letter_cnt[i] = 0;
    win_start  = 0;
    win_size   = 0;
    top_cnt    = 0;
    seen_cnt   = 0;
    overflow   = 1'b0;
    repl_limit = 0;
  end

  function automatic lrwr_out_t advance_window(lrwr_in_t it);
    lrwr_out_t ans;
    int        code;
    int        old;
    code = it.letter_code;
    if (it.string_start) begin
      foreach (letter_cnt[i]) letter_cnt[i] = 0;
      win_start = 0;
      win_size  = 0;
      top_cnt   = 0;
      seen_cnt  = 0;
      overflow  = 1'b0;
    end
    if (code < ALPHABET_SIZE) begin
      if (seen_cnt >= STORE_DEPTH) begin
        overflow = 1'b1;
      end else begin
        letter_mem[seen_cnt % STORE_DEPTH] = code[LETTER_W-1:0];
        letter_cnt[code] = letter_cnt[code] + 1;
        if (letter_cnt[code] > top_cnt) top_cnt = letter_cnt[code];
        win_size = win_size + 1;
        seen_cnt = seen_cnt + 1;
        // drop the letter at the window start once too many would need changing
        if (win_size - top_cnt > repl_limit) begin
          old = letter_mem[win_start % STORE_DEPTH];
          if (old < ALPHABET_SIZE && letter_cnt[old] > 0) letter_cnt[old] = letter_cnt[old] - 1;
          win_start = (win_start + 1) % STORE_DEPTH;
          win_size  = win_size - 1;
        end
      end
    end
    ans.best_length  = win_size[LEN_W-1:0];
    ans.final_result = it.string_end;
    ans.too_long     = overflow;
    return ans;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < PRINT_MAX)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_letter(int code, bit st, bit en);
    lrwr_in_t it;
    it.letter_code  = code[LETTER_W-1:0];
    it.string_start = st;
    it.string_end   = en;
    pending_letters.insert(pending_letters.size(), it);
  endtask

  // Mostly well-formed strings over a few letters, with some noise mixed in
  task automatic queue_random_strings(int budget);
    int  len;
    int  span;
    int  base;
    int  kind;
    int  code;
    bit  st;
    bit  en;
    while (budget > 0) begin
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
      span = ($urandom_range(0, 4) == 0) ? ALPHABET_SIZE : $urandom_range(1, 4);
      base = $urandom_range(0, ALPHABET_SIZE - span);
      kind = $urandom_range(0, 99);
      for (int i = 0; i < len; i++) begin
        code = base + $urandom_range(0, span - 1);
        if ($urandom_range(0, 99) < 4) code = $urandom_range(ALPHABET_SIZE, 31);
        st = (i == 0) && (kind >= 5);
        en = (i == len - 1) && !(kind >= 5 && kind < 10);
        if (kind >= 95 && $urandom_range(0, 7) == 0) st = 1'b1;
        queue_letter(code, st, en);
      end
      budget -= len;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_letters.size() != 0 || item_valid || expected_answers.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_max_replacements(int k);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k[LEN_W-1:0];
    repl_limit = k;
    settings_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Driver: offer pending items, idle between them at random
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
    end else begin
      drv_next_valid = item_valid;
      if (item_valid && item_ready) begin
        expected_answers.insert(expected_answers.size(), advance_window(item));
        letters_sent++;
        drv_next_valid = 1'b0;
        send_gap = burst ? 0 : pick_gap();
      end
      if (!drv_next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_letters.size() > 0) begin
          item <= pending_letters.pop_front();
          drv_next_valid = 1'b1;
        end
      end
      item_valid <= drv_next_valid;
    end
  end

  // Monitor: check each answer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("answer with nothing expected", result.best_length, 0);
        end else begin
          lrwr_out_t want;
          want = expected_answers.pop_front();
          if (result.best_length !== want.best_length)
            report_mismatch("best_length", result.best_length, want.best_length);
          if (result.final_result !== want.final_result)
            report_mismatch("final_result", result.final_result, want.final_result);
          if (result.too_long !== want.too_long)
            report_mismatch("too_long", result.too_long, want.too_long);
          answers_checked++;
          if (want.final_result) strings_closed++;
          if (want.too_long) overflow_answers++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        mon_next_ready = 1'b0;
      end else if (holds_done < holds_wanted) begin
        // hold off long enough for the block to back up into its input
        holds_done++;
        hold_left = LONG_HOLD;
        mon_next_ready = 1'b0;
      end else if (!burst && $urandom_range(0, 99) < 20) begin
        hold_left = pick_gap();
        mon_next_ready = 1'b0;
      end else begin
        mon_next_ready = 1'b1;
      end
      result_ready <= mon_next_ready;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_MAX) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_MAX);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int k_list[8];
    mismatches       = 0;
    letters_sent     = 0;
    answers_checked  = 0;
    strings_closed   = 0;
    overflow_answers = 0;
    settings_used    = 0;
    holds_wanted     = 0;
    holds_done       = 0;
    burst            = 1'b0;
    idle_cycles      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // K = 0 from reset; letters before any string start continue one string
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b1);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(25, 1'b1, 1'b1);
    queue_letter(31, 1'b1, 1'b1);
    queue_letter(0, 1'b1, 1'b0);
    queue_letter(26, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b1);
    wait_drained();

    set_max_replacements(1);
    queue_letter(0, 1'b1, 1'b0);
    queue_letter(1, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b0);
    queue_letter(1, 1'b0, 1'b0);
    queue_letter(16, 1'b0, 1'b0);
    queue_letter(0, 1'b0, 1'b1);
    wait_drained();

    // K at the top: whole length, then a string longer than the store
    set_max_replacements(MAX_K);
    queue_letter(2, 1'b1, 1'b0);
    queue_letter(7, 1'b0, 1'b0);
    queue_letter(19, 1'b0, 1'b0);
    queue_letter(24, 1'b0, 1'b1);
    for (int i = 0; i < STORE_DEPTH + 6; i++)
      queue_letter($urandom_range(0, ALPHABET_SIZE - 1), i == 0, i == STORE_DEPTH + 5);
    queue_letter(3, 1'b0, 1'b0);
    queue_letter(3, 1'b1, 1'b0);
    queue_letter(4, 1'b0, 1'b1);
    wait_drained();

    k_list = '{0, 2, 3, $urandom_range(4, 12), 1023, $urandom_range(0, MAX_K),
               $urandom_range(13, 60), 1};
    for (int p = 0; p < 8; p++) begin
      set_max_replacements(k_list[p]);
      burst = (p == 2 || p == 5);
      if (p == 2) holds_wanted++;
      queue_random_strings(70);
      wait_drained();
    end
    burst = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_answers.size() != 0)
      report_mismatch("answers never delivered", 0, expected_answers.size());
    $display("sent %0d letters under %0d replacement limits, checked %0d answers",
             letters_sent, settings_used + 1, answers_checked);
    $display("closed %0d strings, %0d answers flagged the store overflow",
             strings_closed, overflow_answers);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
